### sv/tfr_pkg.sv
// Shared types, constants and the 5x7 font for the text framebuffer renderer.
package tfr_pkg;

    localparam int DISPLAY_WIDTH_DEF  = 128;
    localparam int DISPLAY_HEIGHT_DEF = 64;
    localparam int FB_BYTES_DEF       = DISPLAY_WIDTH_DEF * ((DISPLAY_HEIGHT_DEF + 7) / 8);

    localparam int CELL_W  = 6;
    localparam int CELL_H  = 8;
    localparam int GLYPH_W = 5;
    localparam int GLYPH_H = 7;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;

    localparam logic [2:0] FUNC_WRITE_CHAR = 3'd0;
    localparam logic [2:0] FUNC_DRAW_PIXEL = 3'd1;
    localparam logic [2:0] FUNC_SET_CURSOR = 3'd2;
    localparam logic [2:0] FUNC_CLEAR      = 3'd3;
    localparam logic [2:0] FUNC_READ_BYTE  = 3'd4;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [7:0] x;
        logic [7:0] y;
        logic       pixel_on;
        logic [9:0] byte_index;
    } tfr_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } tfr_out_t;

    // Store command: a read loads the data register, a write merges the
    // masked bits into the byte held there.
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic [7:0] mask;
        logic [7:0] bits;
    } tfr_mem_cmd_t;

    // One glyph column, bit 0 at the top. Lower case folds to upper case.
    function automatic logic [6:0] glyph_column(input logic [7:0] code,
                                                input logic [2:0] idx);
        logic [7:0]  uc;
        logic [39:0] g;
        logic [7:0]  col;
        uc = code;
        if (code inside {[8'h61:8'h7A]})
            uc = code - 8'h20;
        case (uc)
            8'h41: g = 40'h7E1111117E;
            8'h42: g = 40'h7F49494936;
            8'h43: g = 40'h3E41414122;
            8'h44: g = 40'h7F4141221C;
            8'h45: g = 40'h7F49494941;
            8'h46: g = 40'h7F09090901;
            8'h47: g = 40'h3E4149497A;
            8'h48: g = 40'h7F0808087F;
            8'h49: g = 40'h00417F4100;
            8'h4A: g = 40'h2040413F01;
            8'h4B: g = 40'h7F08142241;
            8'h4C: g = 40'h7F40404040;
            8'h4D: g = 40'h7F020C027F;
            8'h4E: g = 40'h7F0408107F;
            8'h4F: g = 40'h3E4141413E;
            8'h50: g = 40'h7F09090906;
            8'h51: g = 40'h3E4151215E;
            8'h52: g = 40'h7F09192946;
            8'h53: g = 40'h4649494931;
            8'h54: g = 40'h01017F0101;
            8'h55: g = 40'h3F4040403F;
            8'h56: g = 40'h1F2040201F;
            8'h57: g = 40'h3F4038403F;
            8'h58: g = 40'h6314081463;
            8'h59: g = 40'h0708700807;
            8'h5A: g = 40'h6151494543;
            8'h30: g = 40'h3E5149453E;
            8'h31: g = 40'h00427F4000;
            8'h32: g = 40'h4261514946;
            8'h33: g = 40'h2141454B31;
            8'h34: g = 40'h1814127F10;
            8'h35: g = 40'h2745454539;
            8'h36: g = 40'h3C4A494930;
            8'h37: g = 40'h0171090503;
            8'h38: g = 40'h3649494936;
            8'h39: g = 40'h064949291E;
            8'h3A: g = 40'h0036360000;
            8'h2E: g = 40'h0060600000;
            8'h2D: g = 40'h0808080808;
            8'h2F: g = 40'h2010080402;
            8'h3F: g = 40'h0201510906;
            default: g = '0;
        endcase
        case (idx)
            3'd0: col = g[39:32];
            3'd1: col = g[31:24];
            3'd2: col = g[23:16];
            3'd3: col = g[15:8];
            3'd4: col = g[7:0];
            default: col = '0;
        endcase
        return col[6:0];
    endfunction

endpackage

### sv/tfr_frame_mem.sv
// Page-organised pixel store with the shared byte read-modify-write unit.
module tfr_frame_mem
    import tfr_pkg::*;
#(
    parameter int DEPTH = FB_BYTES_DEF
) (
    input  logic                       clk,
    input  tfr_mem_cmd_t               cmd,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] q_reg;
    logic [7:0] merged;

    // mask selects bits taken from the command, the rest keep the last read byte
    assign merged  = (q_reg & ~cmd.mask) | (cmd.bits & cmd.mask);
    assign rd_data = q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
            q_reg <= mem[addr];
        if (cmd.wr)
            mem[addr] <= merged;
    end

endmodule

### sv/text_framebuffer_renderer.sv
// Text framebuffer renderer top level: operation sequencer and result register.
//
// Usage: one request per transfer on req (req_valid/req_ready), one response
// per request on rsp (rsp_valid/rsp_ready), in order. req.func picks the
// operation: write character, draw pixel, set cursor, clear, read byte.
// Every response carries the cursor after the operation; read_data is the
// addressed store byte for a read within the store and zero otherwise.
// All work goes through one store port, a glyph or pixel byte being read
// and then written: write character one byte per glyph column in one
//   page, or two across two pages; newline, set cursor and unused codes
//   none; draw pixel one byte (none off screen), read byte one read (none
//   beyond the store), clear a write to every byte, one byte a cycle.
// One request is in work at a time; req_ready is high only when the
// sequencer is idle. A finished response waits in an output register, so a
// new request is taken while the receiver stalls; that request's response is
// then held at the end of its work until the register frees.
// Reset: cursor goes to 0,0 and the store is swept to zero (FB_BYTES bytes,
// 1024 at the default size), during which no request is taken.
module text_framebuffer_renderer
    import tfr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  tfr_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output tfr_out_t rsp
);

    localparam int FB_PAGES = (DISPLAY_HEIGHT + 7) / 8;
    localparam int FB_BYTES = DISPLAY_WIDTH * FB_PAGES;
    localparam int ADDR_W   = $clog2(FB_BYTES);
    localparam int SUM_W    = ADDR_W + 1;

    localparam logic [7:0]       COL_LIMIT = 8'(DISPLAY_WIDTH - CELL_W);
    localparam logic [7:0]       ROW_LIMIT = 8'(DISPLAY_HEIGHT - CELL_H);
    localparam logic [7:0]       WIDTH_B   = 8'(DISPLAY_WIDTH);
    localparam logic [7:0]       HEIGHT_B  = 8'(DISPLAY_HEIGHT);
    localparam logic [SUM_W-1:0] WIDTH_S   = SUM_W'(DISPLAY_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FB_BYTES - 1);
    localparam logic [2:0]       LAST_COL  = 3'(GLYPH_W - 1);
    localparam logic [14:0]      BOX_MASK  = 15'({GLYPH_H{1'b1}});

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_CLR,
        ST_FETCH,
        ST_CAPTURE,
        ST_DONE
    } state_t;

    state_t            state_reg,  state_next;
    tfr_in_t           op_reg,     op_next;
    logic [7:0]        col_reg,    col_next;
    logic [7:0]        row_reg,    row_next;
    logic [7:0]        rdata_reg,  rdata_next;
    logic [ADDR_W-1:0] base_reg,   base_next;
    logic [2:0]        cidx_reg,   cidx_next;
    logic              pg_reg,     pg_next;
    logic [ADDR_W-1:0] clr_reg,    clr_next;
    logic              boot_reg,   boot_next;
    tfr_out_t          rsp_reg,    rsp_next;
    logic              rsp_vld_reg, rsp_vld_next;

    tfr_mem_cmd_t      mem_cmd;
    logic [ADDR_W-1:0] mem_addr;
    logic [SUM_W-1:0]  addr_sum;
    logic [7:0]        mem_q;

    logic              wrap_hit;
    logic [7:0]        col_w, row_1, row_w;
    logic [4:0]        page_sel;
    logic [7:0]        colsel;
    logic [SUM_W-1:0]  base_sum;
    logic [6:0]        glyph_c;
    logic [14:0]       win_mask, win_bits;
    logic [7:0]        pix_mask;
    logic              need_pg1;
    logic              on_screen;
    logic              in_store;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    // cursor wrap ahead of a glyph: end of line first, then bottom of screen
    assign wrap_hit = col_reg > COL_LIMIT;
    assign col_w    = wrap_hit ? 8'd0 : col_reg;
    assign row_1    = wrap_hit ? row_reg + 8'(CELL_H) : row_reg;
    assign row_w    = (row_1 > ROW_LIMIT) ? 8'd0 : row_1;

    assign page_sel = (op_reg.func == FUNC_DRAW_PIXEL) ? op_reg.y[7:3] : row_w[7:3];
    assign colsel   = (op_reg.func == FUNC_DRAW_PIXEL) ? op_reg.x : col_w;
    assign base_sum = SUM_W'(page_sel) * WIDTH_S + SUM_W'(colsel);

    assign on_screen = (op_reg.x < WIDTH_B) && (op_reg.y < HEIGHT_B);
    assign in_store  = 32'(op_reg.byte_index) < FB_BYTES;

    // glyph column placed across the two pages the box may touch
    assign glyph_c  = glyph_column(op_reg.char_code, cidx_reg);
    assign win_mask = BOX_MASK << row_reg[2:0];
    assign win_bits = {8'd0, glyph_c} << row_reg[2:0];
    assign need_pg1 = win_mask[14:8] != 7'd0;
    assign pix_mask = 8'd1 << op_reg.y[2:0];

    assign addr_sum = SUM_W'(base_reg) + SUM_W'(cidx_reg) + (pg_reg ? WIDTH_S : '0);

    always_comb
    begin
        case (state_reg)
            ST_CLR:   mem_addr = clr_reg;
            ST_FETCH: mem_addr = ADDR_W'(op_reg.byte_index);
            default:  mem_addr = addr_sum[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        mem_cmd.rd = (state_reg == ST_RD) || (state_reg == ST_FETCH);
        mem_cmd.wr = (state_reg == ST_WR) || (state_reg == ST_CLR);
        if (state_reg == ST_CLR)
        begin
            mem_cmd.mask = 8'hFF;
            mem_cmd.bits = 8'h00;
        end
        else if (op_reg.func == FUNC_DRAW_PIXEL)
        begin
            mem_cmd.mask = pix_mask;
            mem_cmd.bits = op_reg.pixel_on ? pix_mask : 8'h00;
        end
        else if (pg_reg)
        begin
            mem_cmd.mask = {1'b0, win_mask[14:8]};
            mem_cmd.bits = {1'b0, win_bits[14:8]};
        end
        else
        begin
            mem_cmd.mask = win_mask[7:0];
            mem_cmd.bits = win_bits[7:0];
        end
    end

    tfr_frame_mem #(
        .DEPTH (FB_BYTES)
    ) u_mem (
        .clk     (clk),
        .cmd     (mem_cmd),
        .addr    (mem_addr),
        .rd_data (mem_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        rdata_next   = rdata_reg;
        base_next    = base_reg;
        cidx_next    = cidx_reg;
        pg_next      = pg_reg;
        clr_next     = clr_reg;
        boot_next    = boot_reg;
        rsp_next     = rsp_reg;
        rsp_vld_next = rsp_vld_reg;

        if (rsp_vld_reg && rsp_ready)
            rsp_vld_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req;
                    rdata_next = 8'd0;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                case (op_reg.func)
                    FUNC_WRITE_CHAR:
                    begin
                        if (op_reg.char_code == NEWLINE_CODE)
                        begin
                            col_next   = 8'd0;
                            row_next   = row_reg + 8'(CELL_H);
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            col_next   = col_w;
                            row_next   = row_w;
                            base_next  = base_sum[ADDR_W-1:0];
                            cidx_next  = 3'd0;
                            pg_next    = 1'b0;
                            state_next = ST_RD;
                        end
                    end
                    FUNC_DRAW_PIXEL:
                    begin
                        if (on_screen)
                        begin
                            base_next  = base_sum[ADDR_W-1:0];
                            cidx_next  = 3'd0;
                            pg_next    = 1'b0;
                            state_next = ST_RD;
                        end
                        else
                            state_next = ST_DONE;
                    end
                    FUNC_SET_CURSOR:
                    begin
                        col_next   = op_reg.x;
                        row_next   = op_reg.y;
                        state_next = ST_DONE;
                    end
                    FUNC_CLEAR:
                    begin
                        col_next   = 8'd0;
                        row_next   = 8'd0;
                        clr_next   = '0;
                        state_next = ST_CLR;
                    end
                    FUNC_READ_BYTE:
                        state_next = in_store ? ST_FETCH : ST_DONE;
                    default:
                        state_next = ST_DONE;
                endcase
            end
            ST_RD:
                state_next = ST_WR;
            ST_WR:
            begin
                if (op_reg.func == FUNC_DRAW_PIXEL)
                    state_next = ST_DONE;
                else if (!pg_reg && need_pg1)
                begin
                    pg_next    = 1'b1;
                    state_next = ST_RD;
                end
                else if (cidx_reg == LAST_COL)
                begin
                    col_next   = col_reg + 8'(CELL_W);
                    state_next = ST_DONE;
                end
                else
                begin
                    cidx_next  = cidx_reg + 3'd1;
                    pg_next    = 1'b0;
                    state_next = ST_RD;
                end
            end
            ST_CLR:
            begin
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_FETCH:
                state_next = ST_CAPTURE;
            ST_CAPTURE:
            begin
                rdata_next = mem_q;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_vld_reg || rsp_ready)
                begin
                    rsp_next.read_data  = rdata_reg;
                    rsp_next.cursor_col = col_reg;
                    rsp_next.cursor_row = row_reg;
                    rsp_vld_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            col_reg     <= 8'd0;
            row_reg     <= 8'd0;
            clr_reg     <= '0;
            boot_reg    <= 1'b1;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            clr_reg     <= clr_next;
            boot_reg    <= boot_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        rdata_reg <= rdata_next;
        base_reg  <= base_next;
        cidx_reg  <= cidx_next;
        pg_reg    <= pg_next;
        rsp_reg   <= rsp_next;
    end

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while another is in work");

    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_cmd.rd && mem_cmd.wr))
        else $error("store read and write in the same cycle");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.rd || mem_cmd.wr) |-> (32'(mem_addr) < FB_BYTES))
        else $error("store access beyond the frame");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the finish step");
`endif

endmodule

### dv/tb.sv
// Testbench for the text framebuffer renderer: directed and random operations.
module tb;
    import tfr_pkg::*;

    localparam int DISP_W      = 128;
    localparam int DISP_H      = 64;
    localparam int FB_BYTES    = DISP_W * ((DISP_H + 7) / 8);
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 30;
    localparam int RANDOM_OPS  = 650;

    // codes with no operation behind them
    localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
    localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    tfr_in_t  req;
    logic     rsp_valid;
    logic     rsp_ready;
    tfr_out_t rsp;

    // local copy of the screen and cursor
    logic [7:0] model_frame [FB_BYTES];
    logic [7:0] model_col;
    logic [7:0] model_row;

    tfr_out_t due_rsp [$];
    int       mismatches = 0;
    int       ops_sent = 0;
    bit       quiet = 1'b0;

    text_framebuffer_renderer #(
        .DISPLAY_WIDTH (DISP_W),
        .DISPLAY_HEIGHT(DISP_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #5 clk = ~clk;

    function automatic logic [39:0] glyph_shape(input logic [7:0] code);
        logic [7:0]  uc;
        logic [39:0] shape;
        uc = code;
        if (code >= "a" && code <= "z")
            uc = code - 8'h20;
        case (uc)
            "A": shape = 40'h7E1111117E;
            "B": shape = 40'h7F49494936;
            "C": shape = 40'h3E41414122;
            "D": shape = 40'h7F4141221C;
            "E": shape = 40'h7F49494941;
            "F": shape = 40'h7F09090901;
            "G": shape = 40'h3E4149497A;
            "H": shape = 40'h7F0808087F;
            "I": shape = 40'h00417F4100;
            "J": shape = 40'h2040413F01;
            "K": shape = 40'h7F08142241;
            "L": shape = 40'h7F40404040;
            "M": shape = 40'h7F020C027F;
            "N": shape = 40'h7F0408107F;
            "O": shape = 40'h3E4141413E;
            "P": shape = 40'h7F09090906;
            "Q": shape = 40'h3E4151215E;
            "R": shape = 40'h7F09192946;
            "S": shape = 40'h4649494931;
            "T": shape = 40'h01017F0101;
            "U": shape = 40'h3F4040403F;
            "V": shape = 40'h1F2040201F;
            "W": shape = 40'h3F4038403F;
            "X": shape = 40'h6314081463;
            "Y": shape = 40'h0708700807;
            "Z": shape = 40'h6151494543;
            "0": shape = 40'h3E5149453E;
            "1": shape = 40'h00427F4000;
            "2": shape = 40'h4261514946;
            "3": shape = 40'h2141454B31;
            "4": shape = 40'h1814127F10;
            "5": shape = 40'h2745454539;
            "6": shape = 40'h3C4A494930;
            "7": shape = 40'h0171090503;
            "8": shape = 40'h3649494936;
            "9": shape = 40'h064949291E;
            ":": shape = 40'h0036360000;
            ".": shape = 40'h0060600000;
            "-": shape = 40'h0808080808;
            "/": shape = 40'h2010080402;
            "?": shape = 40'h0201510906;
            default: shape = '0;
        endcase
        return shape;
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < FB_BYTES; i++)
            model_frame[i] = 8'h00;
        model_col = 8'h00;
        model_row = 8'h00;
    endfunction

    function automatic void plot_px(input int px, input int py, input logic on);
        if (px >= DISP_W || py >= DISP_H)
            return;
        model_frame[px + (py / 8) * DISP_W][py % 8] = on;
    endfunction

    function automatic void put_glyph(input logic [7:0] code);
        logic [39:0] shape;
        logic [7:0]  column;
        int          c;
        int          r;
        if (code == NEWLINE_CODE)
        begin
            model_col = 8'h00;
            model_row = 8'(model_row + CELL_H);
            return;
        end
        if (int'(model_col) > DISP_W - CELL_W)
        begin
            model_col = 8'h00;
            model_row = 8'(model_row + CELL_H);
        end
        if (int'(model_row) > DISP_H - CELL_H)
            model_row = 8'h00;
        shape = glyph_shape(code);
        for (c = 0; c < GLYPH_W; c++)
        begin
            column = shape[39 - 8 * c -: 8];
            for (r = 0; r < GLYPH_H; r++)
                plot_px((int'(model_col) + c) & 255, (int'(model_row) + r) & 255,
                        column[r]);
        end
        model_col = 8'(model_col + CELL_W);
    endfunction

    function automatic tfr_out_t render_model(input tfr_in_t op);
        tfr_out_t res;
        res.read_data = 8'h00;
        case (op.func)
            FUNC_WRITE_CHAR: put_glyph(op.char_code);
            FUNC_DRAW_PIXEL: plot_px(int'(op.x), int'(op.y), op.pixel_on);
            FUNC_SET_CURSOR:
            begin
                model_col = op.x;
                model_row = op.y;
            end
            FUNC_CLEAR:      model_reset();
            FUNC_READ_BYTE:
            begin
                if (int'(op.byte_index) < FB_BYTES)
                    res.read_data = model_frame[op.byte_index];
            end
            default: ;
        endcase
        res.cursor_col = model_col;
        res.cursor_row = model_row;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic tfr_in_t rand_op();
        tfr_in_t op;
        op.func       = 3'($urandom_range(0, 7));
        op.char_code  = 8'($urandom);
        op.x          = 8'($urandom);
        op.y          = 8'($urandom);
        op.pixel_on   = 1'($urandom);
        op.byte_index = 10'($urandom);
        return op;
    endfunction

    // Valid stays high after a transfer; the next call or drain_all decides
    // whether it drops, so it is never lowered and raised in one step.
    task automatic screen_op(input tfr_in_t op);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= op;
        do
            @(negedge clk);
        while (!req_ready);
        @(posedge clk);
        due_rsp.push_back(render_model(op));
        if (op.func <= FUNC_READ_BYTE)
            ops_sent++;
    endtask

    task automatic do_func(input logic [2:0] f);
        tfr_in_t op;
        op      = rand_op();
        op.func = f;
        screen_op(op);
    endtask

    task automatic do_char(input logic [7:0] code);
        tfr_in_t op;
        op           = rand_op();
        op.func      = FUNC_WRITE_CHAR;
        op.char_code = code;
        screen_op(op);
    endtask

    task automatic do_pixel(input logic [7:0] px, input logic [7:0] py, input logic on);
        tfr_in_t op;
        op          = rand_op();
        op.func     = FUNC_DRAW_PIXEL;
        op.x        = px;
        op.y        = py;
        op.pixel_on = on;
        screen_op(op);
    endtask

    task automatic do_cursor(input logic [7:0] cx, input logic [7:0] cy);
        tfr_in_t op;
        op      = rand_op();
        op.func = FUNC_SET_CURSOR;
        op.x    = cx;
        op.y    = cy;
        screen_op(op);
    endtask

    task automatic do_read(input int idx);
        tfr_in_t op;
        op            = rand_op();
        op.func       = FUNC_READ_BYTE;
        op.byte_index = 10'(idx);
        screen_op(op);
    endtask

    task automatic drain_all();
        req_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(posedge clk);
    endtask

    // store is swept to zero at reset; unused codes must leave everything alone
    task automatic test_idle_store();
        do_read(0);
        do_func(FUNC_SPARE_LO);
        do_func(FUNC_SPARE_HI);
    endtask

    task automatic test_glyphs();
        do_char("A");
        do_char("z");
        do_char("?");
        do_char(8'hFF);
        do_char(NEWLINE_CODE);
        do_read(0);
    endtask

    task automatic test_cursor_wrap();
        do_cursor(8'd123, 8'd0);
        do_char("W");
        // column and row both wrap; glyph lands across two pages
        do_cursor(8'd250, 8'd250);
        do_char("X");
        // newline has no row check; the next character folds the row back
        do_cursor(8'd0, 8'd60);
        do_char(NEWLINE_CODE);
        do_char("5");
    endtask

    task automatic test_pixels();
        do_pixel(8'd0, 8'd0, 1'b1);
        do_pixel(8'd127, 8'd63, 1'b1);
        do_pixel(8'd128, 8'd5, 1'b1);
        do_pixel(8'd255, 8'd255, 1'b1);
        do_read(FB_BYTES - 1);
        do_pixel(8'd127, 8'd63, 1'b0);
        do_read(FB_BYTES - 1);
    endtask

    task automatic test_clear();
        do_func(FUNC_CLEAR);
        do_read(0);
    endtask

    function automatic logic [7:0] text_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'("A" + $urandom_range(0, 25));
        if (r < 40)
            return 8'("a" + $urandom_range(0, 25));
        if (r < 58)
            return 8'("0" + $urandom_range(0, 9));
        if (r < 73)
        begin
            case ($urandom_range(0, 4))
                0: return ":";
                1: return ".";
                2: return "-";
                3: return "/";
                default: return "?";
            endcase
        end
        if (r < 81)
            return NEWLINE_CODE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic text_run();
        int cx;
        int cy;
        int n;
        int page;
        cx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                         : CELL_W * $urandom_range(0, 21);
        case ($urandom_range(0, 3))
            0: cy = $urandom_range(0, 255);
            1: cy = $urandom_range(0, DISP_H - 1);
            default: cy = CELL_H * $urandom_range(0, DISP_H / CELL_H - 1);
        endcase
        do_cursor(8'(cx), 8'(cy));
        n = $urandom_range(3, 16);
        repeat (n) do_char(text_code());
        // read back around the glyphs just drawn, both pages under the cell
        repeat (4)
        begin
            page = (int'(model_row) / 8 + $urandom_range(0, 1)) % (FB_BYTES / DISP_W);
            do_read(page * DISP_W
                    + (int'(model_col) + DISP_W - $urandom_range(1, 12)) % DISP_W);
        end
    endtask

    task automatic pixel_run();
        int px;
        int py;
        int n;
        n = $urandom_range(4, 12);
        repeat (n)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                px = $urandom_range(0, 255);
                py = $urandom_range(0, 255);
            end
            else
            begin
                px = $urandom_range(0, DISP_W - 1);
                py = $urandom_range(0, DISP_H - 1);
            end
            do_pixel(8'(px), 8'(py), 1'($urandom_range(0, 1)));
        end
        if (px < DISP_W && py < DISP_H)
            do_read((py / 8) * DISP_W + px);
        do_read($urandom_range(0, FB_BYTES - 1));
    endtask

    task automatic test_random_traffic();
        int      target;
        int      pick;
        tfr_in_t op;
        target = ops_sent + RANDOM_OPS;
        while (ops_sent < target)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            pick  = $urandom_range(0, 199);
            if (pick < 90)
                text_run();
            else if (pick < 140)
                pixel_run();
            else if (pick < 197)
            begin
                op = rand_op();
                if (op.func == FUNC_CLEAR)
                    op.func = FUNC_READ_BYTE;
                screen_op(op);
            end
            else
                do_func(FUNC_CLEAR);
        end
        quiet = 1'b0;
    endtask

    initial
    begin : rsp_stall
        int hold;
        hold = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // both sides are stable at the falling edge, so a transfer seen here
    // completes at the next rising edge
    initial
    begin : rsp_check
        tfr_out_t want;
        forever
        begin
            @(negedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: read_data %h col %0d row %0d",
                                 rsp.read_data, rsp.cursor_col, rsp.cursor_row);
                end
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.read_data !== want.read_data
                            || rsp.cursor_col !== want.cursor_col
                            || rsp.cursor_row !== want.cursor_row)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: read_data exp %h got %h, ",
                                      "col exp %0d got %0d, row exp %0d got %0d"},
                                     want.read_data, rsp.read_data, want.cursor_col,
                                     rsp.cursor_col, want.cursor_row, rsp.cursor_row);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        model_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_store();
        test_glyphs();
        test_cursor_wrap();
        test_pixels();
        test_clear();
        test_random_traffic();

        drain_all();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
